FILE: design/dpq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the deadline priority queue.
package dpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int MCNT_W      = $clog2(MAX_RESULTS + 1);
	localparam int KEY_W       = 26;

	localparam logic [1:0] FN_INSERT    = 2'd0;
	localparam logic [1:0] FN_POP       = 2'd1;
	localparam logic [1:0] FN_LIST_ALL  = 2'd2;
	localparam logic [1:0] FN_LIST_DATE = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_REPORT = 2'd3;

	typedef struct packed {
		logic [7:0]  tag;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  prio;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  task_tag;
		logic [13:0] due_year;
		logic [3:0]  due_month;
		logic [4:0]  due_day;
		logic [4:0]  due_hour;
		logic [5:0]  due_minute;
		logic [2:0]  priority_req;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_tag;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
		logic [2:0]  out_priority;
		logic        last;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_POP,
		S_LIST,
		S_FIN
	} state_t;

	// Map a logical queue position onto the circular storage.
	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
		input logic [CNT_W-1:0] lidx);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(lidx);
		if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	// Sort key: date first, then priority.
	function automatic logic [KEY_W-1:0] key_of(input entry_t e);
		return {e.year, e.month, e.day, e.prio};
	endfunction

	function automatic entry_t to_entry(input cmd_t c);
		entry_t e;
		e.tag    = c.task_tag;
		e.year   = c.due_year;
		e.month  = c.due_month;
		e.day    = c.due_day;
		e.hour   = c.due_hour;
		e.minute = c.due_minute;
		e.prio   = c.priority_req;
		return e;
	endfunction

	function automatic result_t make_result(input logic [1:0] st, input entry_t e,
		input logic lst);
		result_t r;
		r.status       = st;
		r.out_tag      = e.tag;
		r.out_year     = e.year;
		r.out_month    = e.month;
		r.out_day      = e.day;
		r.out_hour     = e.hour;
		r.out_minute   = e.minute;
		r.out_priority = e.prio;
		r.last         = lst;
		return r;
	endfunction

endpackage

FILE: design/dpq_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM with one write port and one registered read port.
module dpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/dpq_outreg.sv
`timescale 1ns / 1ps
// Result output register between the queue controller and the result channel.
module dpq_outreg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dpq_pkg::result_t  push_data,
	output logic              free,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output dpq_pkg::result_t  rsp
);
	import dpq_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign free      = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

endmodule

FILE: design/deadline_priority_queue_unit.sv
`timescale 1ns / 1ps
// Deadline priority queue: sorted task list held in a circular RAM.
//
// Commands arrive on cmd (cmd_valid/cmd_ready); results leave on rsp
// (rsp_valid/rsp_ready). Insert, remove head, list all and list by date.
// Every command ends with one result that has last set; a list gives one
// result per reported entry, at most MAX_RESULTS.
// One command is worked at a time; cmd_ready is high only between commands.
// Insert walks from the tail towards the head, one RAM read and one write
// a cycle, moving each later entry up by one place.
// Remove head moves no entry; only the head pointer advances.
// Lists read one entry a cycle while the receiver does not stall. The single
// RAM read port sets these rates.
// Results go through an output register, so a new command is taken while
// the final result of the last one still waits. When the receiver stalls,
// a list holds its scan until the result register frees.
// Reset empties the queue at once (head and count clear); the RAM itself
// is not cleared, as only stored positions are ever read.
module deadline_priority_queue_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  dpq_pkg::cmd_t     cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output dpq_pkg::result_t  rsp
);
	import dpq_pkg::*;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   head_q, head_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   idx_q, idx_d;
	logic               rvld_q, rvld_d;
	logic               pend_q, pend_d;
	logic [MCNT_W-1:0]  mcnt_q, mcnt_d;
	cmd_t               cmd_q, cmd_d;
	entry_t             pend_e_q, pend_e_d;
	logic [1:0]         fin_code_q, fin_code_d;

	logic               re, we;
	logic [IDX_W-1:0]   raddr, waddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	entry_t             rd_e, new_e;

	logic               push, out_free;
	result_t            push_data;
	logic               match, consume, hit_cap, step;

	assign rd_e  = entry_t'(rdata);
	assign new_e = to_entry(cmd_q);

	dpq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	dpq_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.free      (out_free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		idx_d      = idx_q;
		rvld_d     = rvld_q;
		pend_d     = pend_q;
		mcnt_d     = mcnt_q;
		cmd_d      = cmd_q;
		pend_e_d   = pend_e_q;
		fin_code_d = fin_code_q;
		re         = 1'b0;
		raddr      = '0;
		we         = 1'b0;
		waddr      = '0;
		wdata      = '0;
		push       = 1'b0;
		push_data  = '0;
		match      = (cmd_q.func == FN_LIST_ALL) ||
			(key_of(rd_e) >> 3) == (key_of(new_e) >> 3);
		consume    = 1'b0;
		hit_cap    = 1'b0;
		step       = 1'b0;
		cmd_ready  = (state_q == S_IDLE);

		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_d  = cmd;
					pend_d = 1'b0;
					mcnt_d = '0;
					rvld_d = 1'b0;
					unique case (cmd.func)
						FN_INSERT: begin
							if (count_q == CNT_W'(QUEUE_DEPTH)) begin
								fin_code_d = ST_FULL;
								state_d    = S_FIN;
							end else begin
								idx_d   = count_q;
								state_d = S_INS;
								if (count_q != '0) begin
									re     = 1'b1;
									raddr  = phys(head_q, count_q - 1'b1);
									rvld_d = 1'b1;
								end
							end
						end
						FN_POP: begin
							if (count_q == '0) begin
								fin_code_d = ST_EMPTY;
								state_d    = S_FIN;
							end else begin
								re      = 1'b1;
								raddr   = head_q;
								state_d = S_POP;
							end
						end
						FN_LIST_ALL, FN_LIST_DATE: begin
							idx_d   = '0;
							state_d = S_LIST;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_INS: begin
				if (rvld_q && key_of(rd_e) >= key_of(new_e)) begin
					// Move the later entry up one place and look further down.
					we    = 1'b1;
					waddr = phys(head_q, idx_q);
					wdata = rd_e;
					idx_d = idx_q - 1'b1;
					if (idx_q > CNT_W'(1)) begin
						re     = 1'b1;
						raddr  = phys(head_q, idx_q - CNT_W'(2));
						rvld_d = 1'b1;
					end else begin
						rvld_d = 1'b0;
					end
				end else begin
					we         = 1'b1;
					waddr      = phys(head_q, idx_q);
					wdata      = new_e;
					rvld_d     = 1'b0;
					count_d    = count_q + 1'b1;
					fin_code_d = ST_OK;
					state_d    = S_FIN;
				end
			end
			S_POP: begin
				pend_d     = 1'b1;
				pend_e_d   = rd_e;
				head_d     = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_d    = count_q - 1'b1;
				fin_code_d = ST_OK;
				state_d    = S_FIN;
			end
			S_LIST: begin
				// A new match has to transfer the held one first.
				consume = rvld_q && (!(match && pend_q) || out_free);
				if (consume && match) begin
					if (pend_q) begin
						push      = 1'b1;
						push_data = make_result(ST_REPORT, pend_e_q, 1'b0);
					end
					pend_d   = 1'b1;
					pend_e_d = rd_e;
					mcnt_d   = mcnt_q + 1'b1;
					hit_cap  = (mcnt_q + 1'b1) == MCNT_W'(MAX_RESULTS);
				end
				step = !rvld_q || consume;
				if (step && idx_q < count_q && !hit_cap) begin
					re     = 1'b1;
					raddr  = phys(head_q, idx_q);
					idx_d  = idx_q + 1'b1;
					rvld_d = 1'b1;
				end else if (step) begin
					rvld_d = 1'b0;
				end
				if (hit_cap || (step && !(idx_q < count_q))) begin
					rvld_d     = 1'b0;
					fin_code_d = pend_d ? ST_REPORT : ST_EMPTY;
					state_d    = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					push      = 1'b1;
					push_data = make_result(fin_code_q, pend_q ? pend_e_q : '0, 1'b1);
					pend_d    = 1'b0;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			rvld_q  <= 1'b0;
			pend_q  <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			rvld_q  <= rvld_d;
			pend_q  <= pend_d;
			mcnt_q  <= mcnt_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		pend_e_q   <= pend_e_d;
		fin_code_q <= fin_code_d;
	end

endmodule
